// ===== sv/crcr_pkg.sv =====
// Shared types, constants and helpers for the circle/rectangle collision core.
package crcr_pkg;

   localparam int ROOT_W = 31;
   localparam int QUOT_W = 31;

   localparam logic [1:0] CONTACT_NONE   = 2'd0;
   localparam logic [1:0] CONTACT_NORMAL = 2'd1;
   localparam logic [1:0] CONTACT_FACE   = 2'd2;

   localparam logic [1:0] FACE_LEFT   = 2'd0;
   localparam logic [1:0] FACE_RIGHT  = 2'd1;
   localparam logic [1:0] FACE_TOP    = 2'd2;
   localparam logic [1:0] FACE_BOTTOM = 2'd3;

   localparam logic [2:0] CSR_MIN_X  = 3'd0;
   localparam logic [2:0] CSR_MIN_Y  = 3'd1;
   localparam logic [2:0] CSR_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_REST   = 3'd4;

   localparam logic [16:0] ONE_Q16     = 17'd65536;
   localparam logic [62:0] DIST_SQ_MIN = 63'd43;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [30:0]        radius;
      logic [16:0]        particle_restitution;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic [1:0]         contact;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic [30:0]        width;
      logic [30:0]        height;
      logic [16:0]        rest;
   } csr_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic [30:0]        r;
      logic [16:0]        e;
      logic               neg_x;
      logic               neg_y;
      logic [30:0]        adx;
      logic [30:0]        ady;
      logic [30:0]        root;
      logic [1:0]         contact;
      rsp_type            alt;
   } ctx_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
      logic signed [31:0] res;
      if (x > 48'sd2147483647) res = 32'sh7FFFFFFF;
      else if (x < -48'sd2147483648) res = 32'sh80000000;
      else res = x[31:0];
      return res;
   endfunction

   function automatic logic [16:0] rest_sat(input logic [16:0] v);
      return (v > ONE_Q16) ? ONE_Q16 : v;
   endfunction

endpackage

// ===== sv/crcr_front.sv =====
// Front stages: clamp, squared distances, contact decision and face push result.
module crcr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  crcr_pkg::req_type in_data,
   input  crcr_pkg::csr_type csr,
   output logic              out_valid,
   output crcr_pkg::ctx_type out_ctx,
   output logic [61:0]       out_rad
);
   import crcr_pkg::*;

   typedef struct packed {
      req_type            d;
      logic [30:0]        adx;
      logic [30:0]        ady;
      logic               neg_x;
      logic               neg_y;
      logic [16:0]        e;
      logic signed [32:0] maxx;
      logic signed [32:0] maxy;
   } pass_type;

   // stage 1
   logic signed [32:0] minx_w, miny_w, px_w, py_w, cx_w, cy_w;
   logic signed [33:0] dx_w, dy_w;
   logic [33:0]        adx_w, ady_w;
   logic [16:0]        pe_w, oe_w;
   pass_type           p1_in, p1_ff;
   logic               ok1_in, ok1_ff, v1_ff;

   always_comb begin
      minx_w = $signed({csr.min_x[31], csr.min_x});
      miny_w = $signed({csr.min_y[31], csr.min_y});
      px_w   = $signed({in_data.pos_x[31], in_data.pos_x});
      py_w   = $signed({in_data.pos_y[31], in_data.pos_y});
      p1_in.d    = in_data;
      p1_in.maxx = minx_w + $signed({2'b00, csr.width});
      p1_in.maxy = miny_w + $signed({2'b00, csr.height});
      cx_w = (px_w < minx_w) ? minx_w : ((px_w > p1_in.maxx) ? p1_in.maxx : px_w);
      cy_w = (py_w < miny_w) ? miny_w : ((py_w > p1_in.maxy) ? p1_in.maxy : py_w);
      dx_w = $signed({px_w[32], px_w}) - $signed({cx_w[32], cx_w});
      dy_w = $signed({py_w[32], py_w}) - $signed({cy_w[32], cy_w});
      adx_w = dx_w[33] ? 34'(-dx_w) : 34'(dx_w);
      ady_w = dy_w[33] ? 34'(-dy_w) : 34'(dy_w);
      ok1_in = (adx_w[33:31] == 3'd0) && (ady_w[33:31] == 3'd0);
      p1_in.adx   = adx_w[30:0];
      p1_in.ady   = ady_w[30:0];
      p1_in.neg_x = dx_w[33];
      p1_in.neg_y = dy_w[33];
      pe_w = rest_sat(in_data.particle_restitution);
      oe_w = rest_sat(csr.rest);
      p1_in.e = (pe_w < oe_w) ? pe_w : oe_w;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      ok1_ff <= ok1_in;
   end

   // stage 2
   logic signed [34:0] px35_w, py35_w, dl_w, dr_w, dt_w, db_w;
   logic [61:0]        sqx2_in, sqy2_in, rsq2_in, sqx2_ff, sqy2_ff, rsq2_ff;
   logic [33:0]        dl2_in, dr2_in, dt2_in, db2_in, dl2_ff, dr2_ff, dt2_ff, db2_ff;
   logic signed [49:0] vxe2_in, vye2_in, vxe2_ff, vye2_ff;
   pass_type           p2_ff;
   logic               ok2_ff, v2_ff;

   always_comb begin
      px35_w  = $signed({{3{p1_ff.d.pos_x[31]}}, p1_ff.d.pos_x});
      py35_w  = $signed({{3{p1_ff.d.pos_y[31]}}, p1_ff.d.pos_y});
      sqx2_in = 62'(p1_ff.adx) * 62'(p1_ff.adx);
      sqy2_in = 62'(p1_ff.ady) * 62'(p1_ff.ady);
      rsq2_in = 62'(p1_ff.d.radius) * 62'(p1_ff.d.radius);
      dl_w = px35_w - $signed({{3{csr.min_x[31]}}, csr.min_x});
      dr_w = $signed({{2{p1_ff.maxx[32]}}, p1_ff.maxx}) - px35_w;
      dt_w = py35_w - $signed({{3{csr.min_y[31]}}, csr.min_y});
      db_w = $signed({{2{p1_ff.maxy[32]}}, p1_ff.maxy}) - py35_w;
      dl2_in = dl_w[34] ? 34'(-dl_w) : 34'(dl_w);
      dr2_in = dr_w[34] ? 34'(-dr_w) : 34'(dr_w);
      dt2_in = dt_w[34] ? 34'(-dt_w) : 34'(dt_w);
      db2_in = db_w[34] ? 34'(-db_w) : 34'(db_w);
      vxe2_in = 50'($signed(p1_ff.d.vel_x)) * 50'($signed({1'b0, p1_ff.e}));
      vye2_in = 50'($signed(p1_ff.d.vel_y)) * 50'($signed({1'b0, p1_ff.e}));
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      p2_ff   <= p1_ff;
      ok2_ff  <= ok1_ff;
      sqx2_ff <= sqx2_in;
      sqy2_ff <= sqy2_in;
      rsq2_ff <= rsq2_in;
      dl2_ff  <= dl2_in;
      dr2_ff  <= dr2_in;
      dt2_ff  <= dt2_in;
      db2_ff  <= db2_in;
      vxe2_ff <= vxe2_in;
      vye2_ff <= vye2_in;
   end

   // stage 3
   logic [62:0]        dsq_w;
   logic [1:0]         c3_in, c3_ff, f3_in, f3_ff;
   logic [33:0]        mlr_w, mtb_w;
   logic               lr_r_w, tb_b_w;
   logic signed [49:0] vxb_w, vyb_w;
   logic signed [33:0] tvx3_in, tvy3_in, tvx3_ff, tvy3_ff;
   logic [61:0]        rad3_in, rad3_ff;
   pass_type           p3_ff;
   logic               v3_ff;

   always_comb begin
      dsq_w = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
      if (ok2_ff && (dsq_w <= {1'b0, rsq2_ff}))
         c3_in = (dsq_w >= DIST_SQ_MIN) ? CONTACT_NORMAL : CONTACT_FACE;
      else
         c3_in = CONTACT_NONE;
      rad3_in = (c3_in == CONTACT_NORMAL) ? dsq_w[61:0] : 62'd0;
      lr_r_w = dr2_ff < dl2_ff;
      mlr_w  = lr_r_w ? dr2_ff : dl2_ff;
      tb_b_w = db2_ff < dt2_ff;
      mtb_w  = tb_b_w ? db2_ff : dt2_ff;
      if (mtb_w < mlr_w) f3_in = tb_b_w ? FACE_BOTTOM : FACE_TOP;
      else f3_in = lr_r_w ? FACE_RIGHT : FACE_LEFT;
      vxb_w = vxe2_ff + (vxe2_ff[49] ? 50'sd65535 : 50'sd0);
      vyb_w = vye2_ff + (vye2_ff[49] ? 50'sd65535 : 50'sd0);
      tvx3_in = vxb_w[49:16];
      tvy3_in = vyb_w[49:16];
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      p3_ff   <= p2_ff;
      c3_ff   <= c3_in;
      f3_ff   <= f3_in;
      tvx3_ff <= tvx3_in;
      tvy3_ff <= tvy3_in;
      rad3_ff <= rad3_in;
   end

   // stage 4: face push result
   logic signed [47:0] minx48_w, miny48_w, maxx48_w, maxy48_w, r48_w;
   ctx_type            c4_in, c4_ff;
   logic [61:0]        rad4_ff;
   logic               v4_ff;

   always_comb begin
      minx48_w = $signed({{16{csr.min_x[31]}}, csr.min_x});
      miny48_w = $signed({{16{csr.min_y[31]}}, csr.min_y});
      maxx48_w = $signed({{15{p3_ff.maxx[32]}}, p3_ff.maxx});
      maxy48_w = $signed({{15{p3_ff.maxy[32]}}, p3_ff.maxy});
      r48_w    = $signed({17'd0, p3_ff.d.radius});
      c4_in.pos_x   = p3_ff.d.pos_x;
      c4_in.pos_y   = p3_ff.d.pos_y;
      c4_in.vel_x   = p3_ff.d.vel_x;
      c4_in.vel_y   = p3_ff.d.vel_y;
      c4_in.r       = p3_ff.d.radius;
      c4_in.e       = p3_ff.e;
      c4_in.neg_x   = p3_ff.neg_x;
      c4_in.neg_y   = p3_ff.neg_y;
      c4_in.adx     = p3_ff.adx;
      c4_in.ady     = p3_ff.ady;
      c4_in.root    = 31'd0;
      c4_in.contact = c3_ff;
      c4_in.alt.new_pos_x = p3_ff.d.pos_x;
      c4_in.alt.new_pos_y = p3_ff.d.pos_y;
      c4_in.alt.new_vel_x = p3_ff.d.vel_x;
      c4_in.alt.new_vel_y = p3_ff.d.vel_y;
      c4_in.alt.contact   = c3_ff;
      if (c3_ff == CONTACT_FACE) begin
         case (f3_ff)
            FACE_LEFT: begin
               c4_in.alt.new_pos_x = sat32(minx48_w - r48_w);
               if ($signed(p3_ff.d.vel_x) > 32'sd0)
                  c4_in.alt.new_vel_x = sat32(-$signed({{14{tvx3_ff[33]}}, tvx3_ff}));
            end
            FACE_RIGHT: begin
               c4_in.alt.new_pos_x = sat32(maxx48_w + r48_w);
               if ($signed(p3_ff.d.vel_x) < 32'sd0)
                  c4_in.alt.new_vel_x = sat32(-$signed({{14{tvx3_ff[33]}}, tvx3_ff}));
            end
            FACE_TOP: begin
               c4_in.alt.new_pos_y = sat32(miny48_w - r48_w);
               if ($signed(p3_ff.d.vel_y) > 32'sd0)
                  c4_in.alt.new_vel_y = sat32(-$signed({{14{tvy3_ff[33]}}, tvy3_ff}));
            end
            default: begin
               c4_in.alt.new_pos_y = sat32(maxy48_w + r48_w);
               if ($signed(p3_ff.d.vel_y) < 32'sd0)
                  c4_in.alt.new_vel_y = sat32(-$signed({{14{tvy3_ff[33]}}, tvy3_ff}));
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      c4_ff   <= c4_in;
      rad4_ff <= rad3_ff;
   end

   assign out_valid = v4_ff;
   assign out_ctx   = c4_ff;
   assign out_rad   = rad4_ff;

endmodule

// ===== sv/crcr_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module crcr_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  crcr_pkg::ctx_type in_ctx,
   input  logic [61:0]       in_rad,
   output logic              out_valid,
   output crcr_pkg::ctx_type out_ctx
);
   import crcr_pkg::*;

   logic        v_ff   [ROOT_W];
   ctx_type     c_ff   [ROOT_W];
   logic [61:0] rad_ff [ROOT_W];
   logic [32:0] rem_ff [ROOT_W];
   logic [30:0] q_ff   [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic        v_i;
      ctx_type     c_i;
      logic [61:0] rad_i, rad_in;
      logic [32:0] rem_i, rem_in;
      logic [30:0] q_i, q_in;
      logic [34:0] sh_w, trial_w, diff_w;
      logic        ge_w;

      if (k == 0) begin : g_first
         assign v_i   = in_valid;
         assign c_i   = in_ctx;
         assign rad_i = in_rad;
         assign rem_i = 33'd0;
         assign q_i   = 31'd0;
      end else begin : g_next
         assign v_i   = v_ff[k-1];
         assign c_i   = c_ff[k-1];
         assign rad_i = rad_ff[k-1];
         assign rem_i = rem_ff[k-1];
         assign q_i   = q_ff[k-1];
      end

      always_comb begin
         sh_w    = {rem_i, rad_i[61:60]};
         trial_w = {2'b00, q_i, 2'b01};
         diff_w  = sh_w - trial_w;
         ge_w    = sh_w >= trial_w;
         rem_in  = ge_w ? diff_w[32:0] : sh_w[32:0];
         q_in    = {q_i[29:0], ge_w};
         rad_in  = {rad_i[59:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[k] <= 1'b0;
         else v_ff[k] <= v_i;
      end

      always_ff @(posedge clock) begin
         c_ff[k]   <= c_i;
         rad_ff[k] <= rad_in;
         rem_ff[k] <= rem_in;
         q_ff[k]   <= q_in;
      end
   end

   always_comb begin
      out_ctx      = c_ff[ROOT_W-1];
      out_ctx.root = q_ff[ROOT_W-1];
   end

   assign out_valid = v_ff[ROOT_W-1];

endmodule

// ===== sv/crcr_div.sv =====
// Pipelined restoring divider, two lanes: |d| * 2^30 / root, one bit per stage.
module crcr_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  crcr_pkg::ctx_type in_ctx,
   output logic              out_valid,
   output crcr_pkg::ctx_type out_ctx,
   output logic [30:0]       out_qx,
   output logic [30:0]       out_qy
);
   import crcr_pkg::*;

   logic        v_ff  [QUOT_W];
   ctx_type     c_ff  [QUOT_W];
   logic [30:0] rx_ff [QUOT_W];
   logic [30:0] ry_ff [QUOT_W];
   logic [30:0] qx_ff [QUOT_W];
   logic [30:0] qy_ff [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      logic        v_i, nbx_i, nby_i, gex_w, gey_w;
      ctx_type     c_i;
      logic [30:0] rx_i, ry_i, qx_i, qy_i, rx_in, ry_in, qx_in, qy_in;
      logic [31:0] shx_w, shy_w, dv_w, dfx_w, dfy_w;

      if (k == 0) begin : g_first
         assign v_i   = in_valid;
         assign c_i   = in_ctx;
         assign rx_i  = {1'b0, in_ctx.adx[30:1]};
         assign ry_i  = {1'b0, in_ctx.ady[30:1]};
         assign qx_i  = 31'd0;
         assign qy_i  = 31'd0;
         assign nbx_i = in_ctx.adx[0];
         assign nby_i = in_ctx.ady[0];
      end else begin : g_next
         assign v_i   = v_ff[k-1];
         assign c_i   = c_ff[k-1];
         assign rx_i  = rx_ff[k-1];
         assign ry_i  = ry_ff[k-1];
         assign qx_i  = qx_ff[k-1];
         assign qy_i  = qy_ff[k-1];
         assign nbx_i = 1'b0;
         assign nby_i = 1'b0;
      end

      always_comb begin
         dv_w  = {1'b0, c_i.root};
         shx_w = {rx_i, nbx_i};
         shy_w = {ry_i, nby_i};
         dfx_w = shx_w - dv_w;
         dfy_w = shy_w - dv_w;
         gex_w = shx_w >= dv_w;
         gey_w = shy_w >= dv_w;
         rx_in = gex_w ? dfx_w[30:0] : shx_w[30:0];
         ry_in = gey_w ? dfy_w[30:0] : shy_w[30:0];
         qx_in = {qx_i[29:0], gex_w};
         qy_in = {qy_i[29:0], gey_w};
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[k] <= 1'b0;
         else v_ff[k] <= v_i;
      end

      always_ff @(posedge clock) begin
         c_ff[k]  <= c_i;
         rx_ff[k] <= rx_in;
         ry_ff[k] <= ry_in;
         qx_ff[k] <= qx_in;
         qy_ff[k] <= qy_in;
      end
   end

   assign out_valid = v_ff[QUOT_W-1];
   assign out_ctx   = c_ff[QUOT_W-1];
   assign out_qx    = qx_ff[QUOT_W-1];
   assign out_qy    = qy_ff[QUOT_W-1];

endmodule

// ===== sv/crcr_back.sv =====
// Back stages: normal push, velocity reflection, saturation and result select.
module crcr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  crcr_pkg::ctx_type in_ctx,
   input  logic [30:0]       in_qx,
   input  logic [30:0]       in_qy,
   output logic              out_valid,
   output crcr_pkg::rsp_type out_data
);
   import crcr_pkg::*;

   // b1: signed normal, remaining overlap
   logic signed [31:0] nx1_in, ny1_in, nx1_ff, ny1_ff;
   logic [30:0]        rd1_ff;
   ctx_type            c1_ff;
   logic               v1_ff;

   always_comb begin
      nx1_in = in_ctx.neg_x ? -$signed({1'b0, in_qx}) : $signed({1'b0, in_qx});
      ny1_in = in_ctx.neg_y ? -$signed({1'b0, in_qy}) : $signed({1'b0, in_qy});
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      c1_ff  <= in_ctx;
      nx1_ff <= nx1_in;
      ny1_ff <= ny1_in;
      rd1_ff <= in_ctx.r - in_ctx.root;
   end

   // b2: products
   logic signed [63:0] pox2_ff, poy2_ff, pvx2_ff, pvy2_ff;
   logic signed [31:0] nx2_ff, ny2_ff;
   ctx_type            c2_ff;
   logic               v2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      c2_ff   <= c1_ff;
      nx2_ff  <= nx1_ff;
      ny2_ff  <= ny1_ff;
      pox2_ff <= nx1_ff * $signed({1'b0, rd1_ff});
      poy2_ff <= ny1_ff * $signed({1'b0, rd1_ff});
      pvx2_ff <= $signed(c1_ff.vel_x) * nx1_ff;
      pvy2_ff <= $signed(c1_ff.vel_y) * ny1_ff;
   end

   // b3: scale back to Q16.16, truncating toward zero
   logic signed [63:0] pobx_w, poby_w;
   logic signed [64:0] vs_w, vsb_w;
   logic signed [33:0] offx3_ff, offy3_ff;
   logic signed [34:0] vn3_ff;
   logic signed [31:0] nx3_ff, ny3_ff;
   ctx_type            c3_ff;
   logic               v3_ff;

   always_comb begin
      pobx_w = pox2_ff + (pox2_ff[63] ? 64'sd1073741823 : 64'sd0);
      poby_w = poy2_ff + (poy2_ff[63] ? 64'sd1073741823 : 64'sd0);
      vs_w   = $signed({pvx2_ff[63], pvx2_ff}) + $signed({pvy2_ff[63], pvy2_ff});
      vsb_w  = vs_w + (vs_w[64] ? 65'sd1073741823 : 65'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      c3_ff    <= c2_ff;
      nx3_ff   <= nx2_ff;
      ny3_ff   <= ny2_ff;
      offx3_ff <= pobx_w[63:30];
      offy3_ff <= poby_w[63:30];
      vn3_ff   <= vsb_w[64:30];
   end

   // b4: new position, normal times vn
   logic signed [31:0] npx4_ff, npy4_ff;
   logic signed [66:0] gpx4_ff, gpy4_ff;
   logic               vneg4_ff;
   ctx_type            c4_ff;
   logic               v4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      c4_ff    <= c3_ff;
      vneg4_ff <= vn3_ff[34];
      npx4_ff  <= sat32($signed({{16{c3_ff.pos_x[31]}}, c3_ff.pos_x})
                      + $signed({{14{offx3_ff[33]}}, offx3_ff}));
      npy4_ff  <= sat32($signed({{16{c3_ff.pos_y[31]}}, c3_ff.pos_y})
                      + $signed({{14{offy3_ff[33]}}, offy3_ff}));
      gpx4_ff  <= 67'(nx3_ff) * 67'(vn3_ff);
      gpy4_ff  <= 67'(ny3_ff) * 67'(vn3_ff);
   end

   // b5: scale normal velocity
   logic signed [66:0] gbx_w, gby_w;
   logic signed [36:0] gx5_ff, gy5_ff;
   logic signed [31:0] npx5_ff, npy5_ff;
   logic               vneg5_ff;
   ctx_type            c5_ff;
   logic               v5_ff;

   always_comb begin
      gbx_w = gpx4_ff + (gpx4_ff[66] ? 67'sd1073741823 : 67'sd0);
      gby_w = gpy4_ff + (gpy4_ff[66] ? 67'sd1073741823 : 67'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      c5_ff    <= c4_ff;
      vneg5_ff <= vneg4_ff;
      npx5_ff  <= npx4_ff;
      npy5_ff  <= npy4_ff;
      gx5_ff   <= gbx_w[66:30];
      gy5_ff   <= gby_w[66:30];
   end

   // b6: times (1 + e)
   logic signed [18:0] k_w;
   logic signed [55:0] hx6_ff, hy6_ff;
   logic signed [31:0] npx6_ff, npy6_ff;
   logic               vneg6_ff;
   ctx_type            c6_ff;
   logic               v6_ff;

   assign k_w = $signed({1'b0, {1'b0, ONE_Q16} + {1'b0, c5_ff.e}});

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else v6_ff <= v5_ff;
   end

   always_ff @(posedge clock) begin
      c6_ff    <= c5_ff;
      vneg6_ff <= vneg5_ff;
      npx6_ff  <= npx5_ff;
      npy6_ff  <= npy5_ff;
      hx6_ff   <= 56'(gx5_ff) * 56'(k_w);
      hy6_ff   <= 56'(gy5_ff) * 56'(k_w);
   end

   // b7: reflect, saturate, select
   logic signed [55:0] hbx_w, hby_w;
   logic signed [39:0] tx_w, ty_w;
   rsp_type            r7_in, r7_ff;
   logic               v7_ff;

   always_comb begin
      hbx_w = hx6_ff + (hx6_ff[55] ? 56'sd65535 : 56'sd0);
      hby_w = hy6_ff + (hy6_ff[55] ? 56'sd65535 : 56'sd0);
      tx_w  = hbx_w[55:16];
      ty_w  = hby_w[55:16];
      if (c6_ff.contact == CONTACT_NORMAL) begin
         r7_in.new_pos_x = npx6_ff;
         r7_in.new_pos_y = npy6_ff;
         r7_in.new_vel_x = c6_ff.vel_x;
         r7_in.new_vel_y = c6_ff.vel_y;
         if (vneg6_ff) begin
            r7_in.new_vel_x = sat32($signed({{16{c6_ff.vel_x[31]}}, c6_ff.vel_x})
                                    - $signed({{8{tx_w[39]}}, tx_w}));
            r7_in.new_vel_y = sat32($signed({{16{c6_ff.vel_y[31]}}, c6_ff.vel_y})
                                    - $signed({{8{ty_w[39]}}, ty_w}));
         end
         r7_in.contact = CONTACT_NORMAL;
      end else begin
         r7_in = c6_ff.alt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else v7_ff <= v6_ff;
   end

   always_ff @(posedge clock) begin
      r7_ff <= r7_in;
   end

   assign out_valid = v7_ff;
   assign out_data  = r7_ff;

endmodule

// ===== sv/circle_rect_collision_resolve_core.sv =====
// Top level: circle versus rectangle collision response, registers and pipeline.
// Pipeline from an accepted start to rsp_strobe: 4 front, 31 square root, 31 divide and
// 7 back stages; one beat accepted every cycle, busy stays low.
// Throughput is one item per cycle, set by the fully pipelined root and divider.
// Synchronous reset clears all valid bits and the rectangle registers to zero.
module circle_rect_collision_resolve_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  crcr_pkg::req_type req_data,
   output logic              rsp_strobe,
   output crcr_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import crcr_pkg::*;

   csr_type csr_ff;
   logic    fv_w, sv_w, dv_w;
   ctx_type fc_w, sc_w, dc_w;
   logic [61:0] rad_w;
   logic [30:0] qx_w, qy_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_X:  csr_ff.min_x  <= csr_wdata;
            CSR_MIN_Y:  csr_ff.min_y  <= csr_wdata;
            CSR_WIDTH:  csr_ff.width  <= csr_wdata[30:0];
            CSR_HEIGHT: csr_ff.height <= csr_wdata[30:0];
            CSR_REST:   csr_ff.rest   <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   crcr_front u_front (
      .clock(clock), .reset(reset), .in_valid(start & ~busy), .in_data(req_data),
      .csr(csr_ff), .out_valid(fv_w), .out_ctx(fc_w), .out_rad(rad_w)
   );

   crcr_sqrt u_sqrt (
      .clock(clock), .reset(reset), .in_valid(fv_w), .in_ctx(fc_w), .in_rad(rad_w),
      .out_valid(sv_w), .out_ctx(sc_w)
   );

   crcr_div u_div (
      .clock(clock), .reset(reset), .in_valid(sv_w), .in_ctx(sc_w),
      .out_valid(dv_w), .out_ctx(dc_w), .out_qx(qx_w), .out_qy(qy_w)
   );

   crcr_back u_back (
      .clock(clock), .reset(reset), .in_valid(dv_w), .in_ctx(dc_w),
      .in_qx(qx_w), .in_qy(qy_w), .out_valid(rsp_strobe), .out_data(rsp_data)
   );

endmodule

// ===== test/tb_top.sv =====
// Testbench for the circle/rectangle collision core: predicts each beat and checks results.
`timescale 1ns / 1ps

module tb_top;
   import crcr_pkg::*;

   localparam int LATENCY = 73;
   localparam int WATCHDOG_LIMIT = 2000;

   class collision_scoreboard;
      rsp_type expected_q[$];
      int errors;
      int checked;
      int n_contact[3];
      logic signed [31:0] min_x, min_y;
      logic [30:0] width, height;
      logic [16:0] rest;

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            CSR_MIN_X:  min_x = val;
            CSR_MIN_Y:  min_y = val;
            CSR_WIDTH:  width = val[30:0];
            CSR_HEIGHT: height = val[30:0];
            CSR_REST:   rest = val[16:0];
            default: ;
         endcase
      endfunction

      function longint clamp_q16(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function longint root_floor(longint n);
         longint res, bit_v;
         res = 0;
         bit_v = 64'sd1 << 62;
         while (bit_v > n) bit_v = bit_v >>> 2;
         while (bit_v != 0) begin
            if (n >= res + bit_v) begin
               n = n - (res + bit_v);
               res = (res >>> 1) + bit_v;
            end else begin
               res = res >>> 1;
            end
            bit_v = bit_v >>> 2;
         end
         return res;
      endfunction

      function void note_beat(req_type b);
         longint px, py, vx, vy, r, pe, oe, e, lx, ty, rx, by, cx, cy, dx, dy;
         longint dsq, root_v, nx, ny, vn, gx, gy, dl, dr, dt, db, best;
         logic [1:0] ct;
         logic [1:0] face;
         rsp_type o;
         px = b.pos_x; py = b.pos_y; vx = b.vel_x; vy = b.vel_y;
         r = longint'(b.radius);
         pe = (b.particle_restitution > ONE_Q16) ? 65536 : longint'(b.particle_restitution);
         oe = (rest > ONE_Q16) ? 65536 : longint'(rest);
         e = pe < oe ? pe : oe;
         lx = min_x; ty = min_y;
         rx = lx + longint'(width); by = ty + longint'(height);
         cx = px < lx ? lx : (px > rx ? rx : px);
         cy = py < ty ? ty : (py > by ? by : py);
         dx = px - cx; dy = py - cy;
         ct = CONTACT_NONE;
         if (dx < (64'sd1 << 31) && -dx < (64'sd1 << 31) &&
             dy < (64'sd1 << 31) && -dy < (64'sd1 << 31)) begin
            dsq = dx * dx + dy * dy;
            if (dsq <= r * r) ct = (dsq >= 43) ? CONTACT_NORMAL : CONTACT_FACE;
         end
         if (ct == CONTACT_NORMAL) begin
            root_v = root_floor(dx * dx + dy * dy);
            nx = (dx <<< 30) / root_v;
            ny = (dy <<< 30) / root_v;
            px += nx * (r - root_v) / (64'sd1 << 30);
            py += ny * (r - root_v) / (64'sd1 << 30);
            vn = (vx * nx + vy * ny) / (64'sd1 << 30);
            if (vn < 0) begin
               gx = nx * vn / (64'sd1 << 30);
               gy = ny * vn / (64'sd1 << 30);
               vx -= gx * (65536 + e) / 65536;
               vy -= gy * (65536 + e) / 65536;
            end
         end else if (ct == CONTACT_FACE) begin
            dl = px - lx; if (dl < 0) dl = -dl;
            dr = rx - px; if (dr < 0) dr = -dr;
            dt = py - ty; if (dt < 0) dt = -dt;
            db = by - py; if (db < 0) db = -db;
            best = dl; face = FACE_LEFT;
            if (dr < best) begin best = dr; face = FACE_RIGHT; end
            if (dt < best) begin best = dt; face = FACE_TOP; end
            if (db < best) face = FACE_BOTTOM;
            case (face)
               FACE_LEFT: begin px = lx - r; if (vx > 0) vx = -(vx * e / 65536); end
               FACE_RIGHT: begin px = rx + r; if (vx < 0) vx = -(vx * e / 65536); end
               FACE_TOP: begin py = ty - r; if (vy > 0) vy = -(vy * e / 65536); end
               default: begin py = by + r; if (vy < 0) vy = -(vy * e / 65536); end
            endcase
         end
         o.new_pos_x = 32'(clamp_q16(px));
         o.new_pos_y = 32'(clamp_q16(py));
         o.new_vel_x = 32'(clamp_q16(vx));
         o.new_vel_y = 32'(clamp_q16(vy));
         o.contact = ct;
         expected_q = {expected_q, o};
      endfunction

      function void check_result(rsp_type got);
         rsp_type x;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
            return;
         end
         x = expected_q.pop_front();
         checked++;
         if (got.contact <= 2) n_contact[got.contact]++;
         if (got.new_pos_x !== x.new_pos_x) begin
            $error("new_pos_x exp %0d got %0d", x.new_pos_x, got.new_pos_x); errors++;
         end
         if (got.new_pos_y !== x.new_pos_y) begin
            $error("new_pos_y exp %0d got %0d", x.new_pos_y, got.new_pos_y); errors++;
         end
         if (got.new_vel_x !== x.new_vel_x) begin
            $error("new_vel_x exp %0d got %0d", x.new_vel_x, got.new_vel_x); errors++;
         end
         if (got.new_vel_y !== x.new_vel_y) begin
            $error("new_vel_y exp %0d got %0d", x.new_vel_y, got.new_vel_y); errors++;
         end
         if (got.contact !== x.contact) begin
            $error("contact exp %0d got %0d", x.contact, got.contact); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = CSR_MIN_X;
   logic [31:0] csr_wdata = '0;

   collision_scoreboard sb = new();
   int send_idle_pct = 0;
   int idle_cycles = 0;

   circle_rect_collision_resolve_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_beat(req_data);
         if (rsp_strobe) sb.check_result(rsp_data);
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", sb.expected_q.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
   endtask

   task automatic set_rect(logic [31:0] mx, logic [31:0] my, logic [30:0] w, logic [30:0] h,
                           logic [16:0] e);
      write_csr(CSR_MIN_X, mx);
      write_csr(CSR_MIN_Y, my);
      write_csr(CSR_WIDTH, {1'b0, w});
      write_csr(CSR_HEIGHT, {1'b0, h});
      write_csr(CSR_REST, {15'd0, e});
   endtask

   task automatic drain();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // one beat; start stays high across back-to-back beats
   task automatic send_beat(req_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic stop_sending();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_q16(int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   // particle placed near the current rectangle so that contacts are common
   function automatic req_type near_beat();
      req_type b;
      longint lx, ty;
      lx = sb.min_x; ty = sb.min_y;
      b.pos_x = 32'(lx + longint'($urandom_range(sb.width + 32'd400000)) - 200000);
      b.pos_y = 32'(ty + longint'($urandom_range(sb.height + 32'd400000)) - 200000);
      b.vel_x = ($urandom_range(9) == 0) ? $urandom() : rand_q16(800000);
      b.vel_y = ($urandom_range(9) == 0) ? $urandom() : rand_q16(800000);
      b.radius = 31'(($urandom_range(19) == 0) ? $urandom() : $urandom_range(300000));
      b.particle_restitution = 17'(($urandom_range(9) == 0) ? $urandom()
                                                             : $urandom_range(65536));
      return b;
   endfunction

   function automatic req_type wild_beat();
      req_type b;
      b.pos_x = $urandom(); b.pos_y = $urandom();
      b.vel_x = $urandom(); b.vel_y = $urandom();
      b.radius = 31'($urandom()); b.particle_restitution = 17'($urandom());
      return b;
   endfunction

   function automatic req_type mk(longint px, longint py, longint vx, longint vy,
                                  longint r, longint e);
      req_type b;
      b.pos_x = 32'(px); b.pos_y = 32'(py); b.vel_x = 32'(vx); b.vel_y = 32'(vy);
      b.radius = 31'(r); b.particle_restitution = 17'(e);
      return b;
   endfunction

   initial begin
      req_type b;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rectangle [0,10]x[0,5] in Q16.16, restitution 0.5
      set_rect(32'd0, 32'd0, 31'd655360, 31'd327680, 17'd32768);
      send_beat(mk(-131072, 65536, 65536, 0, 196608, 65536));
      send_beat(mk(-131072, -131072, 65536, 65536, 262144, 65536));
      send_beat(mk(-1000000, 65536, 65536, 0, 65536, 65536));
      send_beat(mk(0, 0, 65536, 65536, 65536, 65536));
      send_beat(mk(65536, 163840, 65536, 0, 65536, 65536));
      send_beat(mk(600000, 163840, -65536, 0, 65536, 65536));
      send_beat(mk(327680, 30000, 0, 65536, 65536, 65536));
      send_beat(mk(327680, 300000, 0, -65536, 65536, 65536));
      send_beat(mk(327680, 163840, 0, 0, 0, 0));
      send_beat(mk(327680, 163840, 0, 0, 1, 131071));
      send_beat(mk(-3, -3, 5, 5, 7, 65536));
      send_beat(mk(-5, 0, 9, 0, 7, 65536));
      send_beat(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                   31'h7FFFFFFF, 17'h1FFFF));
      send_beat(mk(-2147483648, -2147483648, -2147483648, 2147483647,
                   31'h7FFFFFFF, 65536));
      send_beat(mk(100, 100, -2147483648, -2147483648, 31'h7FFFFFFF, 65536));
      stop_sending();
      drain();
      // degenerate rectangle and extreme corner registers
      set_rect(32'h7FFFFFFF, 32'h80000000, 31'd0, 31'h7FFFFFFF, 17'h1FFFF);
      send_beat(mk(2147483647, 0, -5, 7, 100, 65536));
      send_beat(mk(2147483647, 2147483647, 2147483647, -2147483648, 31'h7FFFFFFF, 0));
      send_beat(mk(2147483547, -2147483648, 9, -9, 200, 40000));
      send_beat(mk(-2147483648, 0, 2147483647, 0, 31'h7FFFFFFF, 65536));
      stop_sending();
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         send_idle_pct = (phase < 2) ? 14 : (phase < 4) ? 47 : 0;
         case (phase)
            0: set_rect(rand_q16(400000), rand_q16(400000), 31'($urandom_range(1000000)),
                        31'($urandom_range(1000000)), 17'($urandom_range(65536)));
            1: set_rect(32'h80000000, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF, 17'd65536);
            2: set_rect(rand_q16(1000000), rand_q16(1000000), 31'($urandom_range(3)),
                        31'($urandom_range(500000)), 17'($urandom()));
            3: set_rect($urandom(), $urandom(), 31'($urandom()), 31'($urandom()),
                        17'($urandom()));
            4: set_rect(rand_q16(200000), rand_q16(200000), 31'($urandom_range(600000)),
                        31'd0, 17'd0);
            default: set_rect(32'd0, 32'd0, 31'($urandom_range(700000)),
                              31'($urandom_range(700000)), 17'($urandom_range(65536)));
         endcase
         for (int i = 0; i < 145; i++) begin
            b = ($urandom_range(9) < 8) ? near_beat() : wild_beat();
            send_beat(b);
            if (phase == 4 && i == 70) begin
               stop_sending();
               while (sb.expected_q.size() != 0) @(posedge clock);
            end
         end
         stop_sending();
         drain();
      end

      $display("checked %0d results: %0d clear, %0d normal push, %0d face push",
               sb.checked, sb.n_contact[0], sb.n_contact[1], sb.n_contact[2]);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
